@@ hdl/rtc_pkg.sv @@
`timescale 1ns / 1ps

package rtc_pkg;

    // field widths
    localparam int ModeWidth  = 2;
    localparam int CountWidth = 16;
    localparam int ByteWidth  = 8;
    localparam int AddrWidth  = 5;
    localparam int AccWidth   = 32;
    localparam int FieldCount = 8;
    localparam int SlotWidth  = 3;

    // configuration port
    localparam int ApbAddrWidth = 3;
    localparam int ApbDataWidth = 32;
    localparam logic [CountWidth-1:0] DividerReset = 16'd600;

    // item modes
    typedef enum logic [ModeWidth-1:0] {
        MODE_TICK = 2'd0,
        MODE_CMD  = 2'd1,
        MODE_DATA = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    // command groups in the top three bits of a command byte
    localparam logic [2:0] CMD_SET_RD = 3'b100;
    localparam logic [2:0] CMD_READ   = 3'b101;
    localparam logic [2:0] CMD_SET_WR = 3'b000;
    localparam logic [2:0] CMD_WRITE  = 3'b010;

    // special register addresses
    localparam logic [AddrWidth-1:0] ADDR_STATUS  = 5'h10;
    localparam logic [AddrWidth-1:0] ADDR_ENABLES = 5'h11;

    // interrupt bits in status and enables
    localparam int IRQ_SEC_BIT  = 2;
    localparam int IRQ_MIN_BIT  = 3;
    localparam int IRQ_HOUR_BIT = 4;

    // cascade limits
    localparam logic [7:0] LIMIT_SUB  = 8'd100;
    localparam logic [7:0] LIMIT_SEC  = 8'd60;
    localparam logic [7:0] LIMIT_MIN  = 8'd60;
    localparam logic [7:0] LIMIT_HOUR = 8'd24;

    // first slot kept with an offset of one (day and month)
    localparam logic [SlotWidth-1:0] SLOT_OFFSET = 3'd6;

    typedef struct packed {
        logic [ModeWidth-1:0]  mode;
        logic [CountWidth-1:0] tick_count;
        logic [ByteWidth-1:0]  byte_value;
    } item_t;

    typedef struct packed {
        logic [ByteWidth-1:0] latch_byte;
        logic                 irq_level;
    } result_t;

    // binary to bcd, wraps modulo 160; divide by ten through reciprocal 205/2048
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [18:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = {11'd0, v} * 19'd205;
        q    = prod[15:11];
        r    = v - ({q[4:0], 3'b000} + {2'b00, q[4:0], 1'b0});
        return {q[3:0], 4'b0000} + r;
    endfunction

    // bcd to binary, the result is at most 165 and so never wraps
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
    endfunction

endpackage

@@ hdl/rtc_apb.sv @@
`timescale 1ns / 1ps

module rtc_apb (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtc_pkg::ApbAddrWidth-1:0]  paddr,
    input  logic [rtc_pkg::ApbDataWidth-1:0]  pwdata,
    output logic [rtc_pkg::ApbDataWidth-1:0]  prdata,
    output logic                              pready,
    output logic [rtc_pkg::CountWidth-1:0]    clock_divider
);
    import rtc_pkg::*;

    logic [CountWidth-1:0] divider_reg;
    logic                  divider_sel;

    // register 0 sits at word 0
    assign divider_sel = (paddr[ApbAddrWidth-1] == 1'b0);
    assign pready      = 1'b1;

    // divider register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= DividerReset;
        end
        else if (psel && penable && pwrite && divider_sel)
        begin
            divider_reg <= pwdata[CountWidth-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (divider_sel)
        begin
            prdata = {{(ApbDataWidth-CountWidth){1'b0}}, divider_reg};
        end
    end

    assign clock_divider = divider_reg;

endmodule

@@ hdl/rtc_core.sv @@
`timescale 1ns / 1ps

module rtc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  rtc_pkg::item_t                  item,
    input  logic [rtc_pkg::CountWidth-1:0]  clock_divider,
    output rtc_pkg::result_t                result
);
    import rtc_pkg::*;

    logic [AccWidth-1:0]  acc_reg, acc_next;
    logic [7:0]           fields_reg [FieldCount];
    logic [7:0]           fields_next [FieldCount];
    logic [7:0]           latches_reg [FieldCount];
    logic [7:0]           latches_next [FieldCount];
    logic [AddrWidth-1:0] rd_addr_reg, rd_addr_next;
    logic [AddrWidth-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]           data_reg, data_next;
    logic [7:0]           rlatch_reg, rlatch_next;
    logic [7:0]           enables_reg, enables_next;
    logic [7:0]           status_reg, status_next;
    logic                 irq_reg, irq_next;

    logic [AccWidth-1:0]  acc_sum;
    logic [AccWidth-1:0]  div_ext;
    logic [7:0]           inc [5];
    logic [SlotWidth-1:0] rd_slot;
    logic [SlotWidth-1:0] wr_slot;
    logic [7:0]           rd_raw;
    logic [7:0]           rd_val;
    logic [7:0]           wr_val;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            rd_addr_reg <= '0;
            wr_addr_reg <= '0;
            data_reg    <= '0;
            rlatch_reg  <= '0;
            enables_reg <= '0;
            status_reg  <= '0;
            irq_reg     <= 1'b0;
            for (int i = 0; i < FieldCount; i++)
            begin
                fields_reg[i]  <= '0;
                latches_reg[i] <= '0;
            end
        end
        else
        begin
            acc_reg     <= acc_next;
            rd_addr_reg <= rd_addr_next;
            wr_addr_reg <= wr_addr_next;
            data_reg    <= data_next;
            rlatch_reg  <= rlatch_next;
            enables_reg <= enables_next;
            status_reg  <= status_next;
            irq_reg     <= irq_next;
            for (int i = 0; i < FieldCount; i++)
            begin
                fields_reg[i]  <= fields_next[i];
                latches_reg[i] <= latches_next[i];
            end
        end
    end

    // shared terms
    assign acc_sum = acc_reg + {{(AccWidth-CountWidth){1'b0}}, item.tick_count};
    assign div_ext = {{(AccWidth-CountWidth){1'b0}}, clock_divider};
    assign rd_slot = rd_addr_reg[SlotWidth-1:0];
    assign wr_slot = wr_addr_reg[SlotWidth-1:0];
    assign rd_raw  = rd_addr_reg[SlotWidth] ? latches_reg[rd_slot] : fields_reg[rd_slot];
    assign rd_val  = rd_raw + {7'd0, (rd_slot >= SLOT_OFFSET)};
    assign wr_val  = from_bcd(data_reg) - {7'd0, (wr_slot >= SLOT_OFFSET)};

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            inc[i] = fields_reg[i] + 8'd1;
        end
    end

    // one word of work per cycle in which go is high
    always_comb
    begin
        acc_next     = acc_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        data_next    = data_reg;
        rlatch_next  = rlatch_reg;
        enables_next = enables_reg;
        status_next  = status_reg;
        irq_next     = irq_reg;
        for (int i = 0; i < FieldCount; i++)
        begin
            fields_next[i]  = fields_reg[i];
            latches_next[i] = latches_reg[i];
        end

        if (go)
        begin
            unique case (item.mode)
                MODE_TICK:
                begin
                    if (acc_sum < div_ext)
                    begin
                        acc_next = acc_sum;
                    end
                    else
                    begin
                        acc_next = acc_sum - div_ext;
                        // ten-thousandths and hundredths
                        if (inc[0] < LIMIT_SUB)
                        begin
                            fields_next[0] = inc[0];
                        end
                        else
                        begin
                            fields_next[0] = inc[0] - LIMIT_SUB;
                            if (inc[1] < LIMIT_SUB)
                            begin
                                fields_next[1] = inc[1];
                            end
                            else
                            begin
                                fields_next[1] = inc[1] - LIMIT_SUB;
                                fields_next[2] = inc[2];
                                if (enables_reg[IRQ_SEC_BIT])
                                begin
                                    status_next[IRQ_SEC_BIT] = 1'b1;
                                    irq_next = 1'b1;
                                end
                                // minute carry
                                if (inc[2] >= LIMIT_SEC)
                                begin
                                    fields_next[2] = inc[2] - LIMIT_SEC;
                                    fields_next[3] = inc[3];
                                    if (enables_reg[IRQ_MIN_BIT])
                                    begin
                                        status_next[IRQ_MIN_BIT] = 1'b1;
                                        irq_next = 1'b1;
                                    end
                                    // hour carry
                                    if (inc[3] >= LIMIT_MIN)
                                    begin
                                        fields_next[3] = inc[3] - LIMIT_MIN;
                                        fields_next[4] = inc[4];
                                        if (enables_reg[IRQ_HOUR_BIT])
                                        begin
                                            status_next[IRQ_HOUR_BIT] = 1'b1;
                                            irq_next = 1'b1;
                                        end
                                        // day carry, month never advances
                                        if (inc[4] >= LIMIT_HOUR)
                                        begin
                                            fields_next[4] = inc[4] - LIMIT_HOUR;
                                            fields_next[5] = fields_reg[5] + 8'd1;
                                            fields_next[6] = fields_reg[6] + 8'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                MODE_CMD:
                begin
                    unique case (item.byte_value[7:5])
                        CMD_SET_RD:
                        begin
                            rd_addr_next = item.byte_value[AddrWidth-1:0];
                        end
                        CMD_READ:
                        begin
                            if (rd_addr_reg == ADDR_STATUS)
                            begin
                                rlatch_next = status_reg;
                                status_next = '0;
                                irq_next    = 1'b0;
                            end
                            else if (rd_addr_reg[AddrWidth-1])
                            begin
                                rlatch_next = '0;
                            end
                            else
                            begin
                                rlatch_next = to_bcd(rd_val);
                            end
                        end
                        CMD_SET_WR:
                        begin
                            wr_addr_next = item.byte_value[AddrWidth-1:0];
                        end
                        CMD_WRITE:
                        begin
                            if (wr_addr_reg == ADDR_ENABLES)
                            begin
                                enables_next = data_reg;
                            end
                            else if (!wr_addr_reg[AddrWidth-1])
                            begin
                                if (wr_addr_reg[SlotWidth])
                                begin
                                    latches_next[wr_slot] = wr_val;
                                end
                                else
                                begin
                                    fields_next[wr_slot] = wr_val;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_DATA:
                begin
                    data_next = item.byte_value;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result reflects the state after this word
    assign result.latch_byte = rlatch_next;
    assign result.irq_level  = irq_next;

endmodule

@@ hdl/bcd_real_time_clock.sv @@
`timescale 1ns / 1ps

// path: a word in the input register passes through the core into the result register
// when the result register can take it; until then the word waits in the input register
// throughput: one word per cycle while out_ready allows; the input register and the result
// register are parted, so a word is taken while a result waits if the input one is empty
// reset: rst_n clears all clock state, latches and interrupts at once;
// the divider comes up at 600
module bcd_real_time_clock (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtc_pkg::ApbAddrWidth-1:0]  paddr,
    input  logic [rtc_pkg::ApbDataWidth-1:0]  pwdata,
    output logic [rtc_pkg::ApbDataWidth-1:0]  prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rtc_pkg::ModeWidth-1:0]     mode,
    input  logic [rtc_pkg::CountWidth-1:0]    tick_count,
    input  logic [rtc_pkg::ByteWidth-1:0]     byte_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rtc_pkg::ByteWidth-1:0]     latch_byte,
    output logic                              irq_level
);
    import rtc_pkg::*;

    logic [CountWidth-1:0] clock_divider;
    item_t                 item_reg;
    logic                  item_full_reg;
    result_t               result;
    result_t               result_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  go;

    rtc_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .clock_divider (clock_divider)
    );

    // handshake between the two register stages
    assign advance  = !out_valid_reg || out_ready;
    assign go       = item_full_reg && advance;
    assign in_ready = !item_full_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_full_reg <= 1'b1;
        end
        else if (go)
        begin
            item_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode       <= mode;
            item_reg.tick_count <= tick_count;
            item_reg.byte_value <= byte_value;
        end
    end

    rtc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .item          (item_reg),
        .clock_divider (clock_divider),
        .result        (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign latch_byte = result_reg.latch_byte;
    assign irq_level  = result_reg.irq_level;

endmodule
